// ===== rtl/deq_pkg.sv =====
package deq_pkg;

    typedef enum logic [1:0] {
        CMD_PUSH_FRONT = 2'd0,
        CMD_PUSH_BACK  = 2'd1,
        CMD_POP_FRONT  = 2'd2,
        CMD_POP_BACK   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        STAT_OK    = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } t_status;

    // Operation broadcast to every cell of the chain
    typedef enum logic [2:0] {
        OP_HOLD      = 3'd0,
        OP_SHIFT_R   = 3'd1,
        OP_SHIFT_L   = 3'd2,
        OP_APPEND    = 3'd3,
        OP_DROP_LAST = 3'd4
    } t_cell_op;

    typedef struct packed {
        t_cell_op           op;
        logic signed [31:0] push_value;
    } t_cell_ctrl;

    typedef struct packed {
        t_cmd               cmd;
        logic signed [31:0] push_value;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] pop_value;
        t_status            status;
        logic [4:0]         entry_count;
        logic               is_empty;
    } t_out_item;

endpackage

// ===== rtl/deq_cell.sv =====
module deq_cell (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  deq_pkg::t_cell_ctrl   i_ctrl,
    input  logic signed [31:0]    i_left_value,
    input  logic                  i_left_occ,
    input  logic signed [31:0]    i_right_value,
    input  logic                  i_right_occ,
    input  logic signed [31:0]    i_right_bus,
    output logic signed [31:0]    o_value,
    output logic                  o_occ,
    output logic signed [31:0]    o_bus
);

    logic signed [31:0] r_value;
    logic signed [31:0] n_value;
    logic               r_occ;
    logic               n_occ;
    logic signed [31:0] r_bus;
    logic signed [31:0] n_bus;
    logic               w_is_last;

    assign w_is_last = r_occ && !i_right_occ;

    always_comb begin
        n_value = r_value;
        n_occ   = r_occ;
        case (i_ctrl.op)
            deq_pkg::OP_SHIFT_R: begin
                n_value = i_left_value;
                n_occ   = i_left_occ;
            end
            deq_pkg::OP_SHIFT_L: begin
                n_value = i_right_value;
                n_occ   = i_right_occ;
            end
            deq_pkg::OP_APPEND: begin
                // first free cell takes the new back entry
                if (!r_occ && i_left_occ) begin
                    n_value = i_ctrl.push_value;
                    n_occ   = 1'b1;
                end
            end
            deq_pkg::OP_DROP_LAST: begin
                if (w_is_last) begin
                    n_occ = 1'b0;
                end
            end
            default: begin
                n_value = r_value;
                n_occ   = r_occ;
            end
        endcase
    end

    // Readout chain: the back entry ripples one cell per cycle toward cell 0
    assign n_bus = w_is_last ? r_value : i_right_bus;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= 1'b0;
        end else begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
        r_bus   <= n_bus;
    end

    assign o_value = r_value;
    assign o_occ   = r_occ;
    assign o_bus   = r_bus;

endmodule

// ===== rtl/double_ended_queue.sv =====
// Double-ended queue of signed 32-bit values, DEPTH entries deep.
// Input channel (i_in_valid / o_in_ready / i_in_data) carries a command:
// push front, push back, pop front or pop back, and a value for pushes.
// Output channel (o_out_valid / i_out_ready / o_out_data) returns one result
// per command: popped value, status, entry count and empty flag.
// Entries sit in a row of cells packed from cell 0 (the front); pushes and
// pops at the front shift the whole row by one cell.
// Push front, push back and pop front: result is registered in the cycle after
// the transfer, and one command per cycle is taken while the receiver keeps
// i_out_ready high.
// Pop back: the back entry travels along a readout chain one cell per cycle
// toward cell 0; a wait counter loaded with the number of entries held before
// the pop counts down, and then the result is registered and the entry dropped.
// o_in_ready is low while a pop back is in flight and while a result waits
// that the receiver is not taking; a stalled result holds unchanged.
// Reset (synchronous, active low) empties the queue and drops any pending
// result; no clearing pass is needed, the queue is ready on the next cycle.
module double_ended_queue #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  deq_pkg::t_in_item   i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output deq_pkg::t_out_item  o_out_data
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int EW = (CW > 5) ? CW : 5;

    typedef enum logic {
        S_IDLE,
        S_SWEEP
    } t_state;

    t_state               r_state;
    t_state               n_state;
    logic [CW-1:0]        r_count;
    logic [CW-1:0]        n_count;
    logic [CW-1:0]        r_wait;
    logic [CW-1:0]        n_wait;
    logic                 r_out_valid;
    logic                 n_out_valid;
    deq_pkg::t_out_item   r_out;
    deq_pkg::t_out_item   n_out;
    deq_pkg::t_cell_ctrl  w_ctrl;

    logic signed [31:0]   w_value [DEPTH];
    logic                 w_occ   [DEPTH];
    logic signed [31:0]   w_bus   [DEPTH];
    logic [DEPTH-1:0]     w_occ_vec;

    logic                 w_in_fire;
    logic                 w_out_fire;
    logic                 w_full;
    logic                 w_empty;
    logic                 w_sweep_done;
    logic [EW-1:0]        w_cnt_ext;

    assign w_full       = (r_count == CW'(DEPTH));
    assign w_empty      = (r_count == '0);
    assign o_in_ready   = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign w_in_fire    = i_in_valid && o_in_ready;
    assign w_out_fire   = r_out_valid && i_out_ready;
    assign w_sweep_done = (r_state == S_SWEEP) && (r_wait == '0);

    always_comb begin
        n_state           = r_state;
        n_count           = r_count;
        n_wait            = r_wait;
        n_out_valid       = r_out_valid && !w_out_fire;
        n_out             = r_out;
        w_ctrl.op         = deq_pkg::OP_HOLD;
        w_ctrl.push_value = i_in_data.push_value;

        if (w_in_fire) begin
            n_out_valid     = 1'b1;
            n_out.pop_value = '0;
            n_out.status    = deq_pkg::STAT_OK;
            case (i_in_data.cmd)
                deq_pkg::CMD_PUSH_FRONT: begin
                    if (w_full) begin
                        n_out.status = deq_pkg::STAT_FULL;
                    end else begin
                        w_ctrl.op = deq_pkg::OP_SHIFT_R;
                        n_count   = r_count + 1'b1;
                    end
                end
                deq_pkg::CMD_PUSH_BACK: begin
                    if (w_full) begin
                        n_out.status = deq_pkg::STAT_FULL;
                    end else begin
                        w_ctrl.op = deq_pkg::OP_APPEND;
                        n_count   = r_count + 1'b1;
                    end
                end
                deq_pkg::CMD_POP_FRONT: begin
                    if (w_empty) begin
                        n_out.status = deq_pkg::STAT_EMPTY;
                    end else begin
                        w_ctrl.op       = deq_pkg::OP_SHIFT_L;
                        n_out.pop_value = w_value[0];
                        n_count         = r_count - 1'b1;
                    end
                end
                deq_pkg::CMD_POP_BACK: begin
                    if (w_empty) begin
                        n_out.status = deq_pkg::STAT_EMPTY;
                    end else begin
                        // wait for the back entry to reach cell 0
                        n_out_valid = 1'b0;
                        n_state     = S_SWEEP;
                        n_wait      = r_count;
                    end
                end
                default: begin
                    n_out.status = deq_pkg::STAT_OK;
                end
            endcase
        end else if (r_state == S_SWEEP) begin
            if (w_sweep_done) begin
                w_ctrl.op       = deq_pkg::OP_DROP_LAST;
                n_out_valid     = 1'b1;
                n_out.pop_value = w_bus[0];
                n_out.status    = deq_pkg::STAT_OK;
                n_count         = r_count - 1'b1;
                n_state         = S_IDLE;
            end else begin
                n_wait = r_wait - 1'b1;
            end
        end

        w_cnt_ext         = EW'(n_count);
        n_out.entry_count = w_cnt_ext[4:0];
        n_out.is_empty    = (n_count == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
        r_wait <= n_wait;
        r_out  <= n_out;
    end

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic signed [31:0] w_left_value;
        logic               w_left_occ;
        logic signed [31:0] w_right_value;
        logic               w_right_occ;
        logic signed [31:0] w_right_bus;

        if (i == 0) begin : g_front
            assign w_left_value = i_in_data.push_value;
            assign w_left_occ   = 1'b1;
        end else begin : g_inner_l
            assign w_left_value = w_value[i-1];
            assign w_left_occ   = w_occ[i-1];
        end

        if (i == DEPTH - 1) begin : g_back
            assign w_right_value = '0;
            assign w_right_occ   = 1'b0;
            assign w_right_bus   = '0;
        end else begin : g_inner_r
            assign w_right_value = w_value[i+1];
            assign w_right_occ   = w_occ[i+1];
            assign w_right_bus   = w_bus[i+1];
        end

        deq_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_left_value  (w_left_value),
            .i_left_occ    (w_left_occ),
            .i_right_value (w_right_value),
            .i_right_occ   (w_right_occ),
            .i_right_bus   (w_right_bus),
            .o_value       (w_value[i]),
            .o_occ         (w_occ[i]),
            .o_bus         (w_bus[i])
        );

        assign w_occ_vec[i] = w_occ[i];
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("entry count above depth");

    a_occ_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $countones(w_occ_vec) == int'(r_count))
        else $error("cell occupancy disagrees with entry count");

    a_sweep_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_in_ready)
        else $error("input taken during pop back readout");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_fire && !w_full && (i_in_data.cmd == deq_pkg::CMD_PUSH_FRONT ||
         i_in_data.cmd == deq_pkg::CMD_PUSH_BACK))
        |=> (r_count == $past(r_count) + 1'b1))
        else $error("accepted push did not add an entry");

    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status == deq_pkg::STAT_EMPTY)
        |-> (o_out_data.pop_value == '0))
        else $error("pop on empty returned nonzero value");

endmodule
